// ===== src/tto_pkg.sv =====
`default_nettype none

package tto_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEFAULT = 16;

   // vertices per triangle, vertex-in-triangle tests, edge pairs
   localparam int NUM_VERTS    = 3;
   localparam int INSIDE_FLAGS = 2 * NUM_VERTS;
   localparam int PAIR_FLAGS   = NUM_VERTS * NUM_VERTS;

   // per-stage load enables of the cross-product pipeline
   typedef struct packed {
      logic diff;
      logic mul;
      logic sub;
   } stage_en_type;

   // per-test hits: vertex inside other triangle, edge pair crossing
   typedef struct packed {
      logic [INSIDE_FLAGS-1:0] in_tri;
      logic [PAIR_FLAGS-1:0]   pair_hit;
   } flag_type;

endpackage

`default_nettype wire

// ===== src/tto_xprod.sv =====
`default_nettype none

// Three-stage cross product (u1 - u0) x (v1 - v0):
// edge vectors, then the two products, then their difference.
module tto_xprod #(
   parameter int COORD_BITS = tto_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire tto_pkg::stage_en_type       en,
   input  wire logic signed [COORD_BITS-1:0] u0_x,
   input  wire logic signed [COORD_BITS-1:0] u0_y,
   input  wire logic signed [COORD_BITS-1:0] u1_x,
   input  wire logic signed [COORD_BITS-1:0] u1_y,
   input  wire logic signed [COORD_BITS-1:0] v0_x,
   input  wire logic signed [COORD_BITS-1:0] v0_y,
   input  wire logic signed [COORD_BITS-1:0] v1_x,
   input  wire logic signed [COORD_BITS-1:0] v1_y,
   output logic signed [2*COORD_BITS+2:0]   xp
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS + 2;
   localparam int XW = 2 * COORD_BITS + 3;

   logic signed [DW-1:0] ux_in, uy_in, vx_in, vy_in;
   logic signed [DW-1:0] ux_ff, uy_ff, vx_ff, vy_ff;
   logic signed [PW-1:0] pa_in, pb_in, pa_ff, pb_ff;
   logic signed [XW-1:0] cross_in, cross_ff;

   // stage 1: edge vectors, sign extended
   assign ux_in = DW'(u1_x) - DW'(u0_x);
   assign uy_in = DW'(u1_y) - DW'(u0_y);
   assign vx_in = DW'(v1_x) - DW'(v0_x);
   assign vy_in = DW'(v1_y) - DW'(v0_y);

   // stage 2: products
   assign pa_in = PW'(ux_ff) * PW'(vy_ff);
   assign pb_in = PW'(uy_ff) * PW'(vx_ff);

   // stage 3: difference
   assign cross_in = XW'(pa_ff) - XW'(pb_ff);

   always_ff @(posedge clock) begin
      if (en.diff) begin
         ux_ff <= ux_in;
         uy_ff <= uy_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
      end
      if (en.mul) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (en.sub) begin
         cross_ff <= cross_in;
      end
   end

   assign xp = cross_ff;

endmodule

`default_nettype wire

// ===== src/tto_judge.sv =====
`default_nettype none

// Sign and range tests on the cross products.
module tto_judge #(
   parameter int COORD_BITS = tto_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic signed [2*COORD_BITS+2:0] cp [2][3][3],
   input  wire logic signed [2*COORD_BITS+2:0] cq [2][3],
   input  wire logic signed [2*COORD_BITS+2:0] sd [3][3],
   input  wire logic signed [2*COORD_BITS+2:0] se [3][3],
   input  wire logic signed [2*COORD_BITS+2:0] sf [3][3],
   output tto_pkg::flag_type                   flags
);

   localparam int XW = 2 * COORD_BITS + 3;
   localparam logic signed [XW-1:0] ZERO = '0;

   genvar s, i, k, j;

   // vertex inside: same sign bit as the opposite vertex on every edge
   generate
      for (s = 0; s < 2; s++) begin : g_side
         for (i = 0; i < tto_pkg::NUM_VERTS; i++) begin : g_pt
            logic [tto_pkg::NUM_VERTS-1:0] same;
            for (k = 0; k < tto_pkg::NUM_VERTS; k++) begin : g_edge
               assign same[k] = (cp[s][i][k][XW-1] == cq[s][k][XW-1]);
            end
            assign flags.in_tri[s*tto_pkg::NUM_VERTS + i] = &same;
         end
      end
   endgenerate

   // edge pair crossing: e and f both within [0, d] (or [d, 0]), d nonzero
   generate
      for (i = 0; i < tto_pkg::NUM_VERTS; i++) begin : g_ea
         for (j = 0; j < tto_pkg::NUM_VERTS; j++) begin : g_eb
            logic pos_ok, neg_ok;
            assign pos_ok = (se[i][j] >= ZERO) && (sf[i][j] >= ZERO) &&
                            (se[i][j] <= sd[i][j]) && (sf[i][j] <= sd[i][j]);
            assign neg_ok = (se[i][j] <= ZERO) && (sf[i][j] <= ZERO) &&
                            (se[i][j] >= sd[i][j]) && (sf[i][j] >= sd[i][j]);
            assign flags.pair_hit[i*tto_pkg::NUM_VERTS + j] =
               (sd[i][j] != ZERO) && (sd[i][j][XW-1] ? neg_ok : pos_ok);
         end
      end
   endgenerate

endmodule

`default_nettype wire

// ===== src/triangle_triangle_overlap_2d.sv =====
// Two-triangle overlap test in 2D.
// Input channel req_*: six signed vertices (A then B), each coordinate COORD_BITS wide,
// transferred when req_valid and req_ready are high at a rising clock edge.
// Result channel rsp_*: rsp_overlap is 1 when the triangles touch or overlap,
// transferred when rsp_valid and rsp_ready are both high.
// Throughput: one triangle pair per cycle while rsp_ready does not stall; every
// cross product has its own three-stage unit, so no resource is shared between items.
// Pipeline: five register stages (edge vectors, products, cross products,
// per-test flags, output register); rsp_valid is the output stage's valid bit.
// Stalls: each full stage holds while the one after it is full and not advancing,
// so a low rsp_ready fills the pipeline and then drops req_ready; nothing is
// lost or repeated.
// Reset (synchronous, active high) empties all stages; data registers keep
// stale values that are never shown.
`default_nettype none

module triangle_triangle_overlap_2d #(
   parameter int COORD_BITS = tto_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_tri_a_p1_x,
   input  wire logic signed [COORD_BITS-1:0] req_tri_a_p1_y,
   input  wire logic signed [COORD_BITS-1:0] req_tri_a_p2_x,
   input  wire logic signed [COORD_BITS-1:0] req_tri_a_p2_y,
   input  wire logic signed [COORD_BITS-1:0] req_tri_a_p3_x,
   input  wire logic signed [COORD_BITS-1:0] req_tri_a_p3_y,
   input  wire logic signed [COORD_BITS-1:0] req_tri_b_p1_x,
   input  wire logic signed [COORD_BITS-1:0] req_tri_b_p1_y,
   input  wire logic signed [COORD_BITS-1:0] req_tri_b_p2_x,
   input  wire logic signed [COORD_BITS-1:0] req_tri_b_p2_y,
   input  wire logic signed [COORD_BITS-1:0] req_tri_b_p3_x,
   input  wire logic signed [COORD_BITS-1:0] req_tri_b_p3_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_overlap
);

   localparam int W  = COORD_BITS;
   localparam int XW = 2 * COORD_BITS + 3;
   localparam int NV = tto_pkg::NUM_VERTS;

   // vertex arrays
   logic signed [W-1:0] ax [NV];
   logic signed [W-1:0] ay [NV];
   logic signed [W-1:0] bx [NV];
   logic signed [W-1:0] by [NV];

   assign ax[0] = req_tri_a_p1_x;
   assign ay[0] = req_tri_a_p1_y;
   assign ax[1] = req_tri_a_p2_x;
   assign ay[1] = req_tri_a_p2_y;
   assign ax[2] = req_tri_a_p3_x;
   assign ay[2] = req_tri_a_p3_y;
   assign bx[0] = req_tri_b_p1_x;
   assign by[0] = req_tri_b_p1_y;
   assign bx[1] = req_tri_b_p2_x;
   assign by[1] = req_tri_b_p2_y;
   assign bx[2] = req_tri_b_p3_x;
   assign by[2] = req_tri_b_p3_y;

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;
   tto_pkg::stage_en_type en;

   assign adv5 = !v5_ff || rsp_ready;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign en.diff = adv1;
   assign en.mul  = adv2;
   assign en.sub  = adv3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   // cross products
   logic signed [XW-1:0] cp [2][3][3];
   logic signed [XW-1:0] cq [2][3];
   logic signed [XW-1:0] sd [3][3];
   logic signed [XW-1:0] se [3][3];
   logic signed [XW-1:0] sf [3][3];

   genvar s, i, k, j;

   // vertex-in-triangle: side s=0 tests A's vertices against B, s=1 B against A
   generate
      for (s = 0; s < 2; s++) begin : g_side
         for (k = 0; k < NV; k++) begin : g_edge
            localparam int K0 = (k + 1) % NV;
            localparam int K1 = (k + 2) % NV;
            logic signed [W-1:0] e0x, e0y, e1x, e1y, ox, oy;
            assign e0x = (s == 0) ? bx[K0] : ax[K0];
            assign e0y = (s == 0) ? by[K0] : ay[K0];
            assign e1x = (s == 0) ? bx[K1] : ax[K1];
            assign e1y = (s == 0) ? by[K1] : ay[K1];
            assign ox  = (s == 0) ? bx[k]  : ax[k];
            assign oy  = (s == 0) ? by[k]  : ay[k];

            // opposite vertex side
            tto_xprod #(.COORD_BITS(COORD_BITS)) u_cq (
               .clock(clock), .en(en),
               .u0_x(e0x), .u0_y(e0y), .u1_x(e1x), .u1_y(e1y),
               .v0_x(e0x), .v0_y(e0y), .v1_x(ox),  .v1_y(oy),
               .xp(cq[s][k])
            );

            for (i = 0; i < NV; i++) begin : g_pt
               logic signed [W-1:0] px, py;
               assign px = (s == 0) ? ax[i] : bx[i];
               assign py = (s == 0) ? ay[i] : by[i];

               tto_xprod #(.COORD_BITS(COORD_BITS)) u_cp (
                  .clock(clock), .en(en),
                  .u0_x(e0x), .u0_y(e0y), .u1_x(e1x), .u1_y(e1y),
                  .v0_x(e0x), .v0_y(e0y), .v1_x(px),  .v1_y(py),
                  .xp(cp[s][i][k])
               );
            end
         end
      end
   endgenerate

   // edge pairs: A edge i (A[i] -> A[i+1]) against B edge j (B[j] -> B[j+1])
   generate
      for (i = 0; i < NV; i++) begin : g_ea
         for (j = 0; j < NV; j++) begin : g_eb
            localparam int I1 = (i + 1) % NV;
            localparam int J1 = (j + 1) % NV;

            tto_xprod #(.COORD_BITS(COORD_BITS)) u_d (
               .clock(clock), .en(en),
               .u0_x(ax[i]), .u0_y(ay[i]), .u1_x(ax[I1]), .u1_y(ay[I1]),
               .v0_x(bx[j]), .v0_y(by[j]), .v1_x(bx[J1]), .v1_y(by[J1]),
               .xp(sd[i][j])
            );

            tto_xprod #(.COORD_BITS(COORD_BITS)) u_e (
               .clock(clock), .en(en),
               .u0_x(ax[i]),  .u0_y(ay[i]),  .u1_x(ax[I1]), .u1_y(ay[I1]),
               .v0_x(ax[I1]), .v0_y(ay[I1]), .v1_x(bx[J1]), .v1_y(by[J1]),
               .xp(se[i][j])
            );

            tto_xprod #(.COORD_BITS(COORD_BITS)) u_f (
               .clock(clock), .en(en),
               .u0_x(bx[j]),  .u0_y(by[j]),  .u1_x(bx[J1]), .u1_y(by[J1]),
               .v0_x(ax[I1]), .v0_y(ay[I1]), .v1_x(bx[J1]), .v1_y(by[J1]),
               .xp(sf[i][j])
            );
         end
      end
   endgenerate

   // stage 4: per-test flags
   tto_pkg::flag_type flags_in, flags_ff;

   tto_judge #(.COORD_BITS(COORD_BITS)) u_judge (
      .cp(cp), .cq(cq), .sd(sd), .se(se), .sf(sf),
      .flags(flags_in)
   );

   // stage 5: output register
   logic overlap_in, overlap_ff;
   assign overlap_in = (|flags_ff.in_tri) || (|flags_ff.pair_hit);

   always_ff @(posedge clock) begin
      if (adv4) flags_ff   <= flags_in;
      if (adv5) overlap_ff <= overlap_in;
   end

   assign req_ready   = adv1;
   assign rsp_valid   = v5_ff;
   assign rsp_overlap = overlap_ff;

`ifndef SYNTHESIS
   // full pipeline with a stalled receiver takes no new transfer
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && !rsp_ready) |-> !req_ready)
      else $error("transfer accepted into a full, stalled pipeline");

   // an accepted transfer occupies stage one next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted transfer lost at stage one");

   // a held flag stage keeps its item and its flags
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !adv4) |=> (v4_ff && $stable(flags_ff)))
      else $error("stalled flag stage changed");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
